// File: hdl/chbd_pkg.sv
package chbd_pkg;

  localparam int SIZE_BITS = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

  localparam logic [4:0] HEX_NONE = 5'd16;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       payload;
    logic       last;
    logic [1:0] status;
  } item_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE], [CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z]};
  endfunction

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_NONE;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      v = 5'(c - CH_ZERO);
    end else if (c inside {[CH_LOWER_A:CH_LOWER_F]}) begin
      v = 5'(c - CH_LOWER_A + HEX_LETTER_BASE);
    end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
      v = 5'(c - CH_UPPER_A + HEX_LETTER_BASE);
    end
    return v;
  endfunction

endpackage

// File: hdl/chbd_byte_if.sv
interface chbd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// File: hdl/chbd_result_if.sv
interface chbd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_payload;
  logic       body_end;
  logic [1:0] end_status;

  modport source (output valid, output out_byte, output is_payload, output body_end,
                  output end_status, input ready);
  modport sink (input valid, input out_byte, input is_payload, input body_end,
                input end_status, output ready);
endinterface

// File: hdl/chbd_cfg_if.sv
interface chbd_cfg_if;
  logic valid;
  logic ready;
  logic chunked_mode;

  modport source (output valid, output chunked_mode, input ready);
  modport sink (input valid, input chunked_mode, output ready);
endinterface

// File: hdl/chbd_front.sv
module chbd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  input  logic           cfg_we,
  input  logic           cfg_data,
  output logic           push,
  output chbd_pkg::item_t item
);

  localparam logic [1:0] PH_SKIP = 2'd0;
  localparam logic [1:0] PH_SIZE = 2'd1;
  localparam logic [1:0] PH_DROP = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;
  localparam int SB = chbd_pkg::SIZE_BITS;

  logic          mode;
  logic [1:0]    phase, phase_next;
  logic [SB-1:0] size_value, size_value_next;
  logic          hex_stopped, hex_stopped_next;
  logic [1:0]    drop_count, drop_count_next;
  logic [SB-1:0] bytes_left, bytes_left_next;
  logic          finished, finished_next;

  logic          alnum;
  logic [4:0]    hv;
  logic          pay, body_end, clear_body;
  logic [1:0]    status;

  assign alnum = chbd_pkg::is_alnum(in_byte);
  assign hv = chbd_pkg::hex_digit(in_byte);

  always_comb begin
    phase_next = phase;
    size_value_next = size_value;
    hex_stopped_next = hex_stopped;
    drop_count_next = drop_count;
    bytes_left_next = bytes_left;
    finished_next = finished;
    pay = 1'b0;
    body_end = 1'b0;
    status = chbd_pkg::ST_OK;
    clear_body = 1'b0;
    if (fire) begin
      if (!mode) begin
        pay = 1'b1;
        body_end = in_last;
        clear_body = in_last;
      end else if (finished) begin
        clear_body = in_last;
      end else begin
        case (phase)
          PH_SIZE: begin
            if (alnum) begin
              if (!hex_stopped) begin
                if (hv[4]) begin
                  hex_stopped_next = 1'b1;
                end else if (size_value[SB-1 -: 4] != '0) begin
                  body_end = 1'b1;
                  status = chbd_pkg::ST_OVERFLOW;
                end else begin
                  size_value_next = {size_value[SB-5:0], hv[3:0]};
                end
              end
            end else if (size_value == '0) begin
              body_end = 1'b1;
              status = chbd_pkg::ST_OK;
            end else begin
              bytes_left_next = size_value;
              drop_count_next = 2'd1;
              phase_next = PH_DROP;
            end
          end
          PH_DROP: begin
            drop_count_next = (drop_count != 2'd0) ? drop_count - 2'd1 : drop_count;
            if (drop_count_next == 2'd0) begin
              phase_next = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            pay = 1'b1;
            bytes_left_next = (bytes_left != '0) ? bytes_left - SB'(1) : bytes_left;
            if (bytes_left_next == '0) begin
              phase_next = PH_SKIP;
            end
          end
          default: begin
            phase_next = PH_SKIP;
            if (alnum) begin
              phase_next = PH_SIZE;
              hex_stopped_next = hv[4];
              size_value_next = hv[4] ? '0 : SB'(hv[3:0]);
            end
          end
        endcase
        if (body_end) begin
          finished_next = 1'b1;
        end
        if (in_last && !body_end) begin
          body_end = 1'b1;
          status = (phase_next == PH_SIZE && size_value_next == '0) ?
                   chbd_pkg::ST_OK : chbd_pkg::ST_TRUNCATED;
        end
        clear_body = in_last;
      end
      if (clear_body) begin
        phase_next = PH_SKIP;
        size_value_next = '0;
        hex_stopped_next = 1'b0;
        drop_count_next = 2'd0;
        bytes_left_next = '0;
        finished_next = 1'b0;
      end
    end
  end

  assign push = pay | body_end;
  assign item.data = in_byte;
  assign item.payload = pay;
  assign item.last = body_end;
  assign item.status = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
      phase <= PH_SKIP;
      size_value <= '0;
      hex_stopped <= 1'b0;
      drop_count <= 2'd0;
      bytes_left <= '0;
      finished <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_data;
      end
      phase <= phase_next;
      size_value <= size_value_next;
      hex_stopped <= hex_stopped_next;
      drop_count <= drop_count_next;
      bytes_left <= bytes_left_next;
      finished <= finished_next;
    end
  end

  // A byte marked last always leaves the framing state as after reset.
  a_last_rearms: assert property (@(posedge clk) disable iff (rst)
    fire && in_last |=> phase == PH_SKIP && !finished && bytes_left == '0)
    else $error("chunk state not rearmed after last byte");

  // Once the body is closed, decoding emits nothing until the next last byte.
  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    mode && finished && !in_last |-> !push)
    else $error("result emitted after body end");

  // A payload phase always has bytes still to forward.
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> bytes_left != '0)
    else $error("payload phase with no bytes left");

endmodule

// File: hdl/chbd_fifo.sv
module chbd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  chbd_pkg::item_t push_item,
  input  logic            pop,
  output chbd_pkg::item_t head,
  output logic            full,
  output logic            empty
);

  localparam int DEPTH = chbd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  chbd_pkg::item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10: count <= count + CNT_W'(1);
        2'b01: count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("request pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("request popped from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

// File: hdl/chbd_back.sv
module chbd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  chbd_pkg::item_t       head,
  input  logic                  empty,
  output logic                  pop,
  chbd_result_if.source         tx
);

  logic       vld;
  logic [7:0] data;
  logic       payload;
  logic       last;
  logic [1:0] status;

  assign pop = !empty && (!vld || tx.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (pop) begin
      vld <= 1'b1;
    end else if (tx.ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data <= head.payload ? head.data : 8'd0;
      payload <= head.payload;
      last <= head.last;
      status <= head.last ? head.status : chbd_pkg::ST_OK;
    end
  end

  assign tx.valid = vld;
  assign tx.out_byte = data;
  assign tx.is_payload = payload;
  assign tx.body_end = last;
  assign tx.end_status = status;

  // Every request leaving the block carries a payload byte or closes the body.
  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    vld |-> payload || last)
    else $error("empty request presented");

endmodule

// File: hdl/http_chunked_body_decoder.sv
// A request reaches tx through the queue and then the output register after its byte is accepted.
// Throughput: one byte per cycle; rx.ready is low only while the four-entry
// queue between the framing decoder and the output register is full.
// Bytes that produce no request leave nothing in the queue.
// Reset (rst, synchronous) selects chunked mode, clears the framing state
// and empties the queue; cfg is always ready.
module http_chunked_body_decoder (
  input logic          clk,
  input logic          rst,
  chbd_byte_if.sink    rx,
  chbd_result_if.source tx,
  chbd_cfg_if.sink     cfg
);

  logic            fire;
  logic            push;
  chbd_pkg::item_t push_item;
  chbd_pkg::item_t head;
  logic            full, empty, pop;

  assign rx.ready = !full;
  assign fire = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;

  chbd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .in_byte  (rx.in_byte),
    .in_last  (rx.in_last),
    .cfg_we   (cfg.valid && cfg.ready),
    .cfg_data (cfg.chunked_mode),
    .push     (push),
    .item     (push_item)
  );

  chbd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  chbd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .tx    (tx)
  );

endmodule
